@@ design/bbn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbn_pkg
// Shared constants for the 3x3 edge-normalized box blur.
// ----------------------------------------------------------------------------
package bbn_pkg;

    // Longest row the line stores can hold.
    localparam int MAX_WIDTH = 256;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd128;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd128;

endpackage

@@ design/bbn_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/box_blur_3x3_edge_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_norm
// 3x3 mean blur over a raster pixel stream, normalized at the frame edges
// (divisor 9 inside, 6 on an edge, 4 in a corner). Narrow, short or too wide
// frames pass through unchanged.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Handshake                      Payload
// ---------  ---  -----------------------------  ------------------------------
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: pixel_in, tuser: is_pad
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: pixel_out,
//                                                tlast: frame_end
// cfg        in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// One transfer per cycle is taken in both directions while m_axis_tready
// stays high. In blur mode the first result of a frame needs
// frame_width + 1 input transfers before it (the source drains with
// frame_width + 1 pad items).
// Pipeline: input/counter stage, line-store read and window shift, masked
// sum, reciprocal multiply into the output register. A skid register behind
// the output register lets one more transfer in while a result waits;
// s_axis_tready drops only when the skid register is full.
// Reset (i_rst_n low, synchronous) restores 128 x 128, clears the counters
// and empties the pipeline. Line stores are not cleared: stale entries only
// reach masked window positions.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_norm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel_in
    input  logic                          s_axis_tuser,  // [0] is_pad

    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [7:0] pixel_out
    output logic                          m_axis_tlast,  // frame_end

    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [bbn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bbn_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int SUM_W = 12;   // 9 * 255 fits
    localparam int TOT_W = 18;   // 511 * 511 fits
    localparam int MUL_W = 13;   // reciprocal constants

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

    // Per-item control decided at the input transfer
    typedef struct packed {
        logic pass;    // pass-through item
        logic emit;    // item produces a result
        logic last;    // result closes the frame
        logic left;
        logic right;
        logic up;
        logic down;
    } t_ctrl;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        t_div             div;
        logic [7:0]       pix;
        logic             emit;
        logic             last;
    } t_sum;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } t_res;

    // ------------------------------------------------------------------
    // Configuration and frame counters
    // ------------------------------------------------------------------
    logic [bbn_pkg::CFG_W-1:0] r_w, n_w;
    logic [bbn_pkg::CFG_W-1:0] r_h, n_h;
    logic [TOT_W-1:0]          r_total, n_total;
    logic                      r_blur, n_blur;

    logic [bbn_pkg::COL_W-1:0] r_col, n_col;
    logic [bbn_pkg::CFG_W-1:0] r_row, n_row;
    logic [TOT_W-1:0]          r_emit_cnt, n_emit_cnt;

    logic adv;
    logic in_fire;
    logic cfg_hit;

    logic [7:0]                val;
    logic [bbn_pkg::CFG_W-1:0] c9;
    logic [bbn_pkg::CFG_W-1:0] xc;
    logic [bbn_pkg::CFG_W-1:0] yr;
    logic [bbn_pkg::COL_W:0]   col_inc;
    logic                      win_valid;
    logic                      end_blur;
    logic [TOT_W-1:0]          emit_inc;
    logic                      end_pass;
    t_ctrl                     n_ctrl;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == bbn_pkg::CFG_FRAME_WIDTH ||
                      i_cfg_index == bbn_pkg::CFG_FRAME_HEIGHT);

    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (i_cfg_we && i_cfg_index == bbn_pkg::CFG_FRAME_WIDTH) begin
            n_w = i_cfg_data;
        end
        if (i_cfg_we && i_cfg_index == bbn_pkg::CFG_FRAME_HEIGHT) begin
            n_h = i_cfg_data;
        end
        // Mode and pixel total follow the register values directly.
        n_total = TOT_W'(n_w) * TOT_W'(n_h);
        n_blur  = (n_w >= 9'd5) && (n_h >= 9'd5) &&
                  (32'(n_w) <= 32'(bbn_pkg::MAX_WIDTH));
    end

    always_comb begin
        val     = s_axis_tuser ? 8'd0 : s_axis_tdata;
        c9      = bbn_pkg::CFG_W'(r_col);
        col_inc = {1'b0, r_col} + 1'b1;

        // Window center lags one row plus one pixel behind the input.
        win_valid = (r_row >= 9'd2) || (r_row == 9'd1 && r_col != '0);
        if (r_col != '0) begin
            xc = c9 - 1'b1;
            yr = r_row - 9'd1;
        end else begin
            xc = r_w - 1'b1;
            yr = r_row - 9'd2;
        end
        end_blur = (yr == r_h - 1'b1) && (xc == r_w - 1'b1);

        emit_inc = r_emit_cnt + 1'b1;
        end_pass = (r_total == '0) || (emit_inc >= r_total);

        n_ctrl.pass  = !r_blur;
        n_ctrl.emit  = r_blur ? win_valid : !s_axis_tuser;
        n_ctrl.last  = r_blur ? end_blur  : end_pass;
        n_ctrl.left  = xc != '0;
        n_ctrl.right = xc < r_w - 1'b1;
        n_ctrl.up    = yr != '0;
        n_ctrl.down  = yr < r_h - 1'b1;

        n_col      = r_col;
        n_row      = r_row;
        n_emit_cnt = r_emit_cnt;
        if (cfg_hit) begin
            n_col      = '0;
            n_row      = '0;
            n_emit_cnt = '0;
        end else if (in_fire) begin
            if (r_blur) begin
                if (32'(col_inc) >= 32'(r_w)) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = bbn_pkg::COL_W'(col_inc);
                end
                if (win_valid && end_blur) begin
                    n_col = '0;
                    n_row = '0;
                end
            end else if (!s_axis_tuser) begin
                n_emit_cnt = end_pass ? '0 : emit_inc;
                if (end_pass) begin
                    n_col = '0;
                    n_row = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= bbn_pkg::FRAME_WIDTH_RST;
            r_h        <= bbn_pkg::FRAME_HEIGHT_RST;
            r_total    <= TOT_W'(bbn_pkg::FRAME_WIDTH_RST) *
                          TOT_W'(bbn_pkg::FRAME_HEIGHT_RST);
            r_blur     <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_w        <= n_w;
            r_h        <= n_h;
            r_total    <= n_total;
            r_blur     <= n_blur;
            r_col      <= n_col;
            r_row      <= n_row;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: item register, line-store read data arrives alongside
    // ------------------------------------------------------------------
    logic                      r_s1_valid;
    t_ctrl                     r_s1_ctrl;
    logic [7:0]                r_s1_val;
    logic [bbn_pkg::COL_W-1:0] r_s1_col;

    logic [7:0] top_q;
    logic [7:0] mid_q;
    logic       store_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ctrl <= n_ctrl;
            r_s1_val  <= r_blur ? val : s_axis_tdata;
            r_s1_col  <= r_col;
        end
    end

    // Each column slot rotates: lower row moves up, new pixel enters lower.
    assign store_we = adv && r_s1_valid && !r_s1_ctrl.pass;

    bbn_ram #(
        .WIDTH (bbn_pkg::PIX_W),
        .DEPTH (bbn_pkg::MAX_WIDTH)
    ) u_row_upper (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_s1_col),
        .i_wdata (mid_q),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (top_q)
    );

    bbn_ram #(
        .WIDTH (bbn_pkg::PIX_W),
        .DEPTH (bbn_pkg::MAX_WIDTH)
    ) u_row_lower (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_val),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (mid_q)
    );

    // ------------------------------------------------------------------
    // Stage 2: 3x3 window (index row * 3 + col, col 2 newest)
    // ------------------------------------------------------------------
    logic       r_s2_valid;
    t_ctrl      r_s2_ctrl;
    logic [7:0] r_s2_pix;
    logic [7:0] r_win [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_s2_ctrl <= r_s1_ctrl;
            r_s2_pix  <= r_s1_val;
        end
        if (store_we) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= top_q;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid_q;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_s1_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: masked sum and divisor select
    // ------------------------------------------------------------------
    logic             r_s3_valid;
    t_sum             r_s3;
    t_sum             n_s3;
    logic [SUM_W-1:0] row_sum [3];
    logic [SUM_W-1:0] v_top;
    logic [SUM_W-1:0] v_bot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            row_sum[i] = (r_s2_ctrl.left  ? SUM_W'(r_win[i*3+0]) : '0) +
                         SUM_W'(r_win[i*3+1]) +
                         (r_s2_ctrl.right ? SUM_W'(r_win[i*3+2]) : '0);
        end
        v_top = r_s2_ctrl.up   ? row_sum[0] : '0;
        v_bot = r_s2_ctrl.down ? row_sum[2] : '0;

        n_s3.sum  = v_top + row_sum[1] + v_bot;
        n_s3.pix  = r_s2_pix;
        n_s3.emit = r_s2_ctrl.emit;
        n_s3.last = r_s2_ctrl.last;
        // In blur mode at most one side per axis is outside the frame.
        if (r_s2_ctrl.left && r_s2_ctrl.right && r_s2_ctrl.up && r_s2_ctrl.down) begin
            n_s3.div = DIV_9;
        end else if ((r_s2_ctrl.left && r_s2_ctrl.right) ||
                     (r_s2_ctrl.up && r_s2_ctrl.down)) begin
            n_s3.div = DIV_6;
        end else begin
            n_s3.div = DIV_4;
        end
        if (r_s2_ctrl.pass) begin
            n_s3.div = DIV_4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_s3 <= n_s3;
        end
    end

    // ------------------------------------------------------------------
    // Divide by reciprocal: x/4 = x*4096>>14, x/6 = x*2731>>14,
    // x/9 = x*3641>>15; exact for every sum that can occur.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]       recip;
    logic [SUM_W+MUL_W-1:0] prod;
    logic [7:0]             quot;
    t_res                   n_res;
    logic                   produce;

    always_comb begin
        case (r_s3.div)
            DIV_4:   recip = 13'd4096;
            DIV_6:   recip = 13'd2731;
            DIV_9:   recip = 13'd3641;
            default: recip = 13'd4096;
        endcase
        prod = (SUM_W + MUL_W)'(r_s3.sum) * (SUM_W + MUL_W)'(recip);
        if (r_s3.div == DIV_9) begin
            quot = prod[22:15];
        end else begin
            quot = prod[21:14];
        end
        n_res.pix  = r_s3.pix;
        n_res.last = r_s3.last;
        if (!r_blur) begin
            n_res.pix = r_s3.pix;
        end else begin
            n_res.pix = quot;
        end
    end

    assign produce = adv && r_s3_valid && r_s3.emit;

    // ------------------------------------------------------------------
    // Output register with skid register
    // ------------------------------------------------------------------
    logic r_out_valid;
    t_res r_out;
    logic r_skid_valid;
    t_res r_skid;

    assign adv = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (produce) begin
            r_skid <= n_res;
        end
    end

    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.pix;
    assign m_axis_tlast  = r_out.last;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 edge-normalized box blur. A queue-fed
// driver pushes pixel and pad transfers into the input stream. A scoreboard
// mirrors the line stores, the window and the position counters, predicts
// each blurred or passed-through pixel, and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb_top;

    import bbn_pkg::*;

    localparam int      CLK_HALF    = 6;
    localparam int      RST_CYC     = 6;
    localparam int      LAT_CYC     = 16;      // pipeline + skid, with margin
    localparam int      HOLD_CYC    = 400;     // long output hold-off
    localparam int      RAND_ITEMS  = 1900;
    localparam int      MAX_REPORTS = 100;
    localparam longint  TIMEOUT_NS  = 64'd12_000_000;

    // Value mix used for the pixels of one frame.
    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_HIGH,
        PIX_LOW
    } pix_style_e;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             is_pad;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } blur_res_t;

    // ------------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] pixel_in
    logic                 s_axis_tuser  = 1'b0; // [0] is_pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [7:0] pixel_out
    logic                 m_axis_tlast;         // frame_end
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    box_blur_3x3_edge_norm u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard state: mirror of the block after reset
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_w = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] cfg_h = FRAME_HEIGHT_RST;
    logic [7:0]       line_upper [MAX_WIDTH] = '{default: 8'd0};
    logic [7:0]       line_lower [MAX_WIDTH] = '{default: 8'd0};
    logic [7:0]       win_pix    [9]         = '{default: 8'd0};
    int unsigned      col_pos   = 0;
    int unsigned      row_pos   = 0;
    int unsigned      emit_cnt  = 0;

    pix_item_t   pixel_src_q[$];     // transfers waiting for the driver
    blur_res_t   exp_pixels_q[$];    // predicted output pixels, oldest first
    blur_res_t   exp_res;
    blur_res_t   pred_res;
    bit          pred_valid;
    bit          in_taken     = 1'b0; // input transfer at the last rising edge
    int          err_cnt      = 0;
    int unsigned stim_cnt     = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;
    int unsigned hold_cnt     = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("box_blur_3x3_edge_norm: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_pos();
        col_pos  = 0;
        row_pos  = 0;
        emit_cnt = 0;
    endfunction

    function automatic bit is_passthru();
        return (cfg_w < 5) || (cfg_h < 5) || (cfg_w > MAX_WIDTH);
    endfunction

    // One input transfer in, zero or one output pixel out.
    task automatic predict_blur(input logic [7:0] pix, input logic pad,
                                output bit produced, output blur_res_t res);
        int unsigned w, h, c, r, yr, xc, sum, cnt, total;
        int          ri, ci;
        logic [7:0]  val, top, mid;
        bit          emit, left, right, up, down, at_end;
        produced = 1'b0;
        res      = '0;
        w        = cfg_w;
        h        = cfg_h;
        if (is_passthru()) begin
            // Short, narrow or too wide frame: pixels go straight through, pads vanish
            total = w * h;
            if (!pad) begin
                emit_cnt++;
                at_end = (total == 0) || (emit_cnt >= total);
                if (at_end) clear_pos();
                produced  = 1'b1;
                res.value = pix;
                res.last  = at_end;
            end
        end else begin
            // Pads enter the line stores as zero, wherever they land
            val = pad ? 8'd0 : pix;
            c   = col_pos;
            r   = row_pos;
            if (c >= w) begin
                clear_pos();
                c = 0;
                r = 0;
            end
            top           = line_upper[c];
            mid           = line_lower[c];
            line_upper[c] = mid;
            line_lower[c] = val;
            for (ri = 0; ri < 3; ri++) begin
                win_pix[ri*3]   = win_pix[ri*3+1];
                win_pix[ri*3+1] = win_pix[ri*3+2];
            end
            win_pix[2] = top;
            win_pix[5] = mid;
            win_pix[8] = val;

            // Window center lags the input by one row plus one pixel
            emit = (r >= 2) || (r == 1 && c >= 1);
            if (c >= 1) begin
                yr = r - 1;
                xc = c - 1;
            end else begin
                yr = r - 2;
                xc = w - 1;
            end
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
            end

            if (emit) begin
                left  = xc > 0;
                right = xc < w - 1;
                up    = yr > 0;
                down  = yr < h - 1;
                sum   = 0;
                for (ri = 0; ri < 3; ri++) begin
                    for (ci = 0; ci < 3; ci++) begin
                        if (!((ri == 0 && !up) || (ri == 2 && !down) ||
                              (ci == 0 && !left) || (ci == 2 && !right)))
                            sum += win_pix[ri*3+ci];
                    end
                end
                // Divisor 9 inside, 6 on an edge, 4 in a corner
                cnt = (1 + int'(left) + int'(right)) * (1 + int'(up) + int'(down));
                at_end = (yr == h - 1) && (xc == w - 1);
                emit_cnt++;
                if (at_end) clear_pos();
                produced  = 1'b1;
                res.value = 8'(sum / cnt);
                res.last  = at_end;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: changes at the falling edge, holds until the transfer
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pixel_src_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_src_q[0].pixel;
                s_axis_tuser  <= pixel_src_q[0].is_pad;
                void'(pixel_src_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output ready: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= HOLD_CYC;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check output transfers, then predict from input transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;

            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_pixels_q.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: output transfer expected none, actual pixel %0d last %0b",
                                 $time, m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end else begin
                    exp_res = exp_pixels_q.pop_front();
                    if (m_axis_tdata !== exp_res.value) begin
                        if (err_cnt < MAX_REPORTS)
                            $display("%0t: pixel_out expected %0d, actual %0d",
                                     $time, exp_res.value, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== exp_res.last) begin
                        if (err_cnt < MAX_REPORTS)
                            $display("%0t: frame_end expected %0b, actual %0b",
                                     $time, exp_res.last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                predict_blur(s_axis_tdata, s_axis_tuser, pred_valid, pred_res);
                if (pred_valid) exp_pixels_q.push_back(pred_res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [7:0] pix, input logic pad);
        pixel_src_q.push_back('{pixel: pix, is_pad: pad});
        // pads in pass-through mode are dropped by the block, so not counted
        if (!(pad && is_passthru())) stim_cnt++;
    endtask

    function automatic logic [7:0] pick_pixel(input pix_style_e style);
        case (style)
            PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_HIGH:    return 8'hF0 | 8'($urandom_range(15));
            PIX_LOW:     return 8'($urandom_range(15));
            default:     return 8'($urandom);
        endcase
    endfunction

    // Queue n_pix pixels at the current setting. In blur mode a drained frame
    // gets width + 1 pads; a broken frame swaps pads and pixels at random and
    // misses the pad count by up to two. In pass-through mode stray pads are
    // sprinkled in, which the block must ignore.
    task automatic send_frame(input int unsigned n_pix, input bit drain,
                              input bit broken, input pix_style_e style);
        int unsigned k, n_pad;
        bit          swap;
        for (k = 0; k < n_pix; k++) begin
            if (is_passthru() && $urandom_range(99) < 6)
                push_item(8'($urandom), 1'b1);
            swap = broken && ($urandom_range(99) < 8);
            push_item(pick_pixel(style), swap);
        end
        if (!is_passthru() && drain) begin
            n_pad = cfg_w + 1;
            if (broken) n_pad = n_pad + $urandom_range(4) - 2;
            for (k = 0; k < n_pad; k++) begin
                swap = broken && ($urandom_range(99) < 8);
                push_item(8'($urandom), !swap);
            end
        end
    endtask

    // Block idle: all input accepted, all results seen, pipeline flushed.
    task automatic wait_idle();
        while (pixel_src_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (exp_pixels_q.size() != 0) @(posedge i_clk);
        repeat (LAT_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        // any write restarts the frame position
        if (idx == CFG_FRAME_WIDTH) cfg_w = CFG_W'(value);
        else                        cfg_h = CFG_W'(value);
        clear_pos();
    endtask

    task automatic configure(input int unsigned w, input int unsigned h);
        wait_idle();
        if ($urandom_range(1)) begin
            write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
        end else begin
            write_reg(CFG_FRAME_HEIGHT, h);
            write_reg(CFG_FRAME_WIDTH, w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned fw, fh, kind, n_frames, k, phase;
        bit          big_done;
        bit          broken;
        pix_style_e  style;
        big_done = 1'b0;
        phase    = 0;

        repeat (RST_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest blur frame, all full scale. The center slot is a
        // pad standing in for a pixel (taken as zero), and the last drain slot
        // carries a pixel where a pad belongs.
        src_idle_pct = 30;
        snk_idle_pct = 73;
        configure(5, 5);
        for (k = 0; k < 25; k++) push_item(8'hFF, (k == 12));
        for (k = 0; k < 6; k++) push_item(8'hFF, (k != 5));

        // Directed: pass-through frame with a stray pad; frame_end on pixel 8
        configure(4, 2);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h55, 1'b0);
        push_item(8'hC3, 1'b1);
        push_item(8'hAA, 1'b0);
        push_item(8'h0F, 1'b0);
        push_item(8'hF0, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h80, 1'b0);

        // Random: receiver-heavy idling, then sender-heavy, then none
        stim_cnt = 0;
        while (stim_cnt < RAND_ITEMS) begin
            if (stim_cnt < 120) begin
                src_idle_pct = 30;
                snk_idle_pct = 73;
            end else if (stim_cnt < 240) begin
                src_idle_pct = 73;
                snk_idle_pct = 30;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            style  = pix_style_e'($urandom_range(3));
            broken = ($urandom_range(99) < 25);

            if (src_idle_pct == 0 && !big_done) begin
                // Widest line store, full frame; the long output hold-off
                // fills the pipeline while the sender keeps offering.
                big_done = 1'b1;
                configure(MAX_WIDTH, 5);
                hold_req = 1'b1;
                send_frame(MAX_WIDTH * 5, 1'b1, 1'b0, style);
            end else if (phase == 0) begin
                // Single-column, tallest frame; partial run, aborted by the
                // next register write
                configure(1, MAX_WIDTH);
                send_frame($urandom_range(20, 60), 1'b0, 1'b0, style);
            end else if (phase == 1) begin
                configure(MAX_WIDTH, $urandom_range(1, 4));
                send_frame($urandom_range(20, 60), 1'b0, 1'b0, style);
            end else begin
                kind = $urandom_range(99);
                if (kind < 55) begin
                    // small blur frames, back to back at one setting
                    fw = $urandom_range(5, 12);
                    fh = $urandom_range(5, 8);
                    configure(fw, fh);
                    n_frames = $urandom_range(1, 2);
                    for (k = 0; k < n_frames; k++)
                        send_frame(fw * fh, 1'b1, broken, style);
                end else if (kind < 80) begin
                    // short or narrow frames pass straight through
                    if ($urandom_range(1)) begin
                        fw = $urandom_range(1, 4);
                        fh = $urandom_range(1, 9);
                    end else begin
                        fw = $urandom_range(1, 9);
                        fh = $urandom_range(1, 4);
                    end
                    configure(fw, fh);
                    n_frames = $urandom_range(1, 2);
                    for (k = 0; k < n_frames; k++)
                        send_frame(fw * fh, 1'b1, broken, style);
                end else if (kind < 90) begin
                    // pass-through with a far-off frame end, cut short
                    if ($urandom_range(1)) configure(MAX_WIDTH, $urandom_range(1, 4));
                    else                   configure($urandom_range(1, 4), MAX_WIDTH);
                    send_frame($urandom_range(20, 60), 1'b0, 1'b0, style);
                end else begin
                    // tall blur frame, a few rows only, then aborted
                    fw = $urandom_range(5, 8);
                    configure(fw, MAX_WIDTH);
                    send_frame(fw * $urandom_range(6, 12), 1'b0, broken, style);
                end
            end
            phase++;
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("box_blur_3x3_edge_norm: match");
        end else begin
            $display("box_blur_3x3_edge_norm: mismatch");
        end
        $finish;
    end

endmodule
